[sv/kevq_pkg.sv]
package kevq_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_SLOT_COUNT  = 128;

  localparam int SLOT_W    = 8;
  localparam int ENTRY_W   = SLOT_W + 1;
  localparam int COUNT_W   = 6;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] F_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] F_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] F_PEEK   = 3'd2;
  localparam logic [FUNC_W-1:0] F_NEXT   = 3'd3;
  localparam logic [FUNC_W-1:0] F_QUERY  = 3'd4;
  localparam logic [FUNC_W-1:0] F_REMOVE = 3'd5;
  localparam logic [FUNC_W-1:0] F_START  = 3'd6;
  localparam logic [FUNC_W-1:0] F_STOP   = 3'd7;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    logic              press;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   event_slot;
    logic                event_press;
    logic                found;
    logic [COUNT_W-1:0]  stored_count;
    logic [COUNT_W-1:0]  deferred_count;
    logic                defer_on;
  } rsp_t;

endpackage

[sv/kevq_ram.sv]
module kevq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/kevq_engine.sv]
module kevq_engine #(
  parameter int QUEUE_DEPTH = kevq_pkg::DEF_QUEUE_DEPTH,
  parameter int SLOT_COUNT  = kevq_pkg::DEF_SLOT_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  kevq_pkg::req_t                 req,
  output logic                           done_valid,
  input  logic                           done_ready,
  output kevq_pkg::rsp_t                 done,
  output logic                           mem_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr,
  output logic [kevq_pkg::ENTRY_W-1:0]   mem_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr,
  input  logic [kevq_pkg::ENTRY_W-1:0]   mem_rdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]    state, state_next;
  logic [PW-1:0] head, head_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] looked, looked_next;
  logic          defer, defer_next;
  logic [CW-1:0] scan_off, scan_off_next;
  logic          scan_vld, scan_vld_next;
  logic [CW-1:0] wr_off, wr_off_next;
  logic [kevq_pkg::ENTRY_W-1:0] key, key_next;
  logic [kevq_pkg::STATUS_W-1:0] status, status_next;
  logic [kevq_pkg::ENTRY_W-1:0]  evt, evt_next;
  logic          found, found_next;

  logic [CW-1:0] wr_ofs, rd_ofs;
  logic [2:0]    op;
  logic          match;

  // ring position of an offset from the pop cursor
  function automatic logic [PW-1:0] pos(input logic [PW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign req_ready  = (state == S_IDLE);
  assign done_valid = (state == S_EMIT);
  assign match      = scan_vld && (mem_rdata == key);

  always_comb begin
    op = req.func;
    if (op == kevq_pkg::F_NEXT) begin
      op = defer ? kevq_pkg::F_PEEK : kevq_pkg::F_POP;
    end
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    held_next     = held;
    looked_next   = looked;
    defer_next    = defer;
    scan_off_next = scan_off;
    scan_vld_next = 1'b0;
    wr_off_next   = wr_off;
    key_next      = key;
    status_next   = status;
    evt_next      = evt;
    found_next    = found;
    mem_we        = 1'b0;
    mem_wdata     = {req.slot, req.press};
    wr_ofs        = held;
    rd_ofs        = looked;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          status_next = kevq_pkg::ST_DONE;
          evt_next    = '0;
          found_next  = 1'b0;
          state_next  = S_EMIT;
          case (op)
            kevq_pkg::F_PUSH: begin
              if ({1'b0, req.slot} >= 9'(SLOT_COUNT)) begin
                status_next = kevq_pkg::ST_RANGE;
              end else if (held == CW'(QUEUE_DEPTH)) begin
                status_next = kevq_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                held_next = held + CW'(1);
              end
            end
            kevq_pkg::F_POP: begin
              if (held == '0) begin
                status_next = kevq_pkg::ST_NONE;
              end else begin
                rd_ofs      = '0;
                head_next   = pos(head, CW'(1));
                held_next   = held - CW'(1);
                looked_next = '0;
                state_next  = S_READ;
              end
            end
            kevq_pkg::F_PEEK: begin
              if (looked >= held) begin
                status_next = kevq_pkg::ST_NONE;
              end else begin
                looked_next = looked + CW'(1);
                state_next  = S_READ;
              end
            end
            kevq_pkg::F_QUERY: begin
              key_next      = {req.slot, req.press};
              scan_off_next = '0;
              state_next    = S_SCAN;
            end
            kevq_pkg::F_REMOVE: begin
              if (looked == '0) begin
                status_next = kevq_pkg::ST_NONE;
              end else if (looked == CW'(1)) begin
                head_next   = pos(head, CW'(1));
                held_next   = held - CW'(1);
                looked_next = '0;
              end else begin
                // fetch the entry below the one to overwrite
                rd_ofs      = looked - CW'(2);
                wr_off_next = looked - CW'(1);
                state_next  = S_SHIFT;
              end
            end
            kevq_pkg::F_START: defer_next = 1'b1;
            default:           defer_next = 1'b0;
          endcase
        end
      end
      S_READ: begin
        evt_next   = mem_rdata;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (match) begin
          found_next = 1'b1;
          state_next = S_EMIT;
        end else if (scan_off == looked) begin
          state_next = S_EMIT;
        end else if (scan_off < looked) begin
          rd_ofs        = scan_off;
          scan_off_next = scan_off + CW'(1);
          scan_vld_next = 1'b1;
        end
      end
      S_SHIFT: begin
        // move one deferred entry up; the next read is two places below
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        wr_ofs    = wr_off;
        if (wr_off == CW'(1)) begin
          head_next   = pos(head, CW'(1));
          held_next   = held - CW'(1);
          looked_next = looked - CW'(1);
          state_next  = S_EMIT;
        end else begin
          rd_ofs      = wr_off - CW'(2);
          wr_off_next = wr_off - CW'(1);
        end
      end
      S_EMIT: begin
        if (done_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    mem_waddr = pos(head, wr_ofs);
    mem_raddr = pos(head, rd_ofs);
  end

  always_comb begin
    done.status         = status;
    done.event_slot     = evt[kevq_pkg::ENTRY_W-1:1];
    done.event_press    = evt[0];
    done.found          = found;
    done.stored_count   = kevq_pkg::COUNT_W'(held);
    done.deferred_count = kevq_pkg::COUNT_W'(looked);
    done.defer_on       = defer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      held     <= '0;
      looked   <= '0;
      defer    <= 1'b0;
      scan_vld <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      held     <= held_next;
      looked   <= looked_next;
      defer    <= defer_next;
      scan_vld <= scan_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_off <= scan_off_next;
    wr_off   <= wr_off_next;
    key      <= key_next;
    status   <= status_next;
    evt      <= evt_next;
    found    <= found_next;
  end

  a_peek_within_held: assert property (@(posedge clk) disable iff (rst)
    looked <= held)
    else $error("peek cursor beyond push cursor");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(QUEUE_DEPTH))
    else $error("held count beyond queue depth");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_SHIFT))
    else $error("entry write outside push or shift");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != S_IDLE)
    else $error("transaction accepted without leaving idle");

endmodule

[sv/key_event_queue_with_defer_unit.sv]
// Channel | Handshake            | Payload          | Direction
// req     | req_valid/req_ready  | kevq_pkg::req_t  | command in
// rsp     | rsp_valid/rsp_ready  | kevq_pkg::rsp_t  | one result per command, out
//
// One command at a time; the entry RAM has one read and one write port.
// Push, mode switch and rejected commands go straight to the result; pop and peek first read the RAM.
// Query: one RAM read per deferred entry, stops on a hit.
// Remove last deferred: one entry moved per cycle.
// Reset clears the cursors and the mode; the entry RAM is not cleared.
// A new command is taken while the previous result waits in the output register.
module key_event_queue_with_defer_unit #(
  parameter int QUEUE_DEPTH = kevq_pkg::DEF_QUEUE_DEPTH,
  parameter int SLOT_COUNT  = kevq_pkg::DEF_SLOT_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  kevq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output kevq_pkg::rsp_t rsp
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic                         done_valid;
  logic                         done_ready;
  kevq_pkg::rsp_t               done;
  logic                         mem_we;
  logic [PW-1:0]                mem_waddr;
  logic [kevq_pkg::ENTRY_W-1:0] mem_wdata;
  logic [PW-1:0]                mem_raddr;
  logic [kevq_pkg::ENTRY_W-1:0] mem_rdata;

  kevq_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .done      (done),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  kevq_ram #(
    .WIDTH(kevq_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register: hold the result until the transaction completes
  assign done_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      rsp <= done;
    end
  end

endmodule
